>>> hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int ELEM_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * ELEM_W;
	localparam int ADJ_W    = 2 * ELEM_W + 1;
	localparam int TERM_W   = 3 * ELEM_W + 2;
	localparam int DET_W    = 3 * ELEM_W + 3;
	localparam int NUM_W    = ADJ_W + 2 * FRAC_W;
	localparam int REM_W    = DET_W + ELEM_W + 1;
	localparam int FRONT_ST = 6;
	localparam int DIV_ST   = ELEM_W + 2;
	localparam int TOTAL_ST = FRONT_ST + DIV_ST;

	// adjugate entry k = a[p]*a[q] - a[r]*a[s]
	localparam logic [3:0] COF_IDX [9][4] = '{
		'{4'd8, 4'd4, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd8, 4'd1}, '{4'd5, 4'd1, 4'd4, 4'd2},
		'{4'd6, 4'd5, 4'd8, 4'd3}, '{4'd8, 4'd0, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd5, 4'd0},
		'{4'd7, 4'd3, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd7, 4'd0}, '{4'd4, 4'd0, 4'd3, 4'd1}
	};

	typedef struct packed {
		logic signed [ELEM_W-1:0] a_00;
		logic signed [ELEM_W-1:0] a_01;
		logic signed [ELEM_W-1:0] a_02;
		logic signed [ELEM_W-1:0] a_10;
		logic signed [ELEM_W-1:0] a_11;
		logic signed [ELEM_W-1:0] a_12;
		logic signed [ELEM_W-1:0] a_20;
		logic signed [ELEM_W-1:0] a_21;
		logic signed [ELEM_W-1:0] a_22;
	} mat_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv_00;
		logic signed [ELEM_W-1:0] inv_01;
		logic signed [ELEM_W-1:0] inv_02;
		logic signed [ELEM_W-1:0] inv_10;
		logic signed [ELEM_W-1:0] inv_11;
		logic signed [ELEM_W-1:0] inv_12;
		logic signed [ELEM_W-1:0] inv_20;
		logic signed [ELEM_W-1:0] inv_21;
		logic signed [ELEM_W-1:0] inv_22;
		logic                     singular;
	} inv_t;

endpackage

>>> hw/rtl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// 3x3 Q16.16 matrix inverse by adjugate over determinant. One matrix word is
// taken per cycle when the output side does not stall: six stages form the
// cofactors, split 32x33 products and the exact determinant, then each of nine
// lanes runs a one-bit-per-stage restoring divider (32 stages plus a range
// check and a saturate stage). Quotients truncate toward zero and saturate to
// the Q16.16 range; a zero determinant gives all-zero entries with singular
// set. Stalls are per stage, so empty stages still fill while the output word
// waits.
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_ready,
	input  mat_t mat,
	output logic inv_valid,
	input  logic inv_ready,
	output inv_t inv
);

	logic [TOTAL_ST-1:0] vld_q;
	logic [TOTAL_ST-1:0] en;
	logic [NUM_W-1:0]    num_s6 [9];
	logic [8:0]          neg_s6;
	logic [DET_W-1:0]    dmag_s6;
	logic                zero_s6;
	logic signed [ELEM_W-1:0] res [9];
	logic [DIV_ST-1:0]   sing_s;
	logic                in_acc;
	logic                out_acc;

	// a stage loads when it is empty or its word moves on
	always_comb begin
		en[TOTAL_ST-1] = !vld_q[TOTAL_ST-1] || inv_ready;
		for (int k = TOTAL_ST - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign mat_ready = en[0];
	assign inv_valid = vld_q[TOTAL_ST-1];
	assign in_acc    = mat_valid && mat_ready;
	assign out_acc   = inv_valid && inv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= mat_valid;
			for (int k = 1; k < TOTAL_ST; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	mi3_front u_front (
		.clk     (clk),
		.en      (en[FRONT_ST-1:0]),
		.mat     (mat),
		.num_s6  (num_s6),
		.neg_s6  (neg_s6),
		.dmag_s6 (dmag_s6),
		.zero_s6 (zero_s6)
	);

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div u_div (
			.clk   (clk),
			.en    (en[TOTAL_ST-1:FRONT_ST]),
			.num   (num_s6[k]),
			.dmag  (dmag_s6),
			.neg   (neg_s6[k]),
			.zero  (zero_s6),
			.res_s (res[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en[FRONT_ST])
			sing_s[0] <= zero_s6;
		for (int k = 1; k < DIV_ST; k++)
			if (en[FRONT_ST+k])
				sing_s[k] <= sing_s[k-1];
	end

	assign inv.inv_00   = res[0];
	assign inv.inv_01   = res[1];
	assign inv.inv_02   = res[2];
	assign inv.inv_10   = res[3];
	assign inv.inv_11   = res[4];
	assign inv.inv_12   = res[5];
	assign inv.inv_20   = res[6];
	assign inv.inv_21   = res[7];
	assign inv.inv_22   = res[8];
	assign inv.singular = sing_s[DIV_ST-1];

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && inv.singular) |-> (inv.inv_00 == '0 && inv.inv_11 == '0 &&
			inv.inv_22 == '0 && inv.inv_01 == '0 && inv.inv_20 == '0))
		else $error("singular word with nonzero entries");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) == $past($countones(vld_q)) + $past(32'(in_acc))
			- $past(32'(out_acc))))
		else $error("pipeline word count mismatch");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> mat_ready)
		else $error("input stalled with an empty stage");

endmodule

>>> hw/rtl/mi3_front.sv
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; (
	input  logic                 clk,
	input  logic [FRONT_ST-1:0]  en,
	input  mat_t                 mat,
	output logic [NUM_W-1:0]     num_s6 [9],
	output logic [8:0]           neg_s6,
	output logic [DET_W-1:0]     dmag_s6,
	output logic                 zero_s6
);

	logic signed [ELEM_W-1:0] elem [9];
	logic signed [PROD_W-1:0] p0_s1 [9];
	logic signed [PROD_W-1:0] p1_s1 [9];
	logic signed [ELEM_W-1:0] c_s1 [3];
	logic signed [ELEM_W-1:0] c_s2 [3];
	logic signed [ADJ_W-1:0]  adj_s2 [9];
	logic signed [ADJ_W-1:0]  adj_s3 [9];
	logic signed [ADJ_W-1:0]  adj_s4 [9];
	logic signed [ADJ_W-1:0]  adj_s5 [9];
	logic signed [PROD_W:0]   pl_s3 [3];
	logic signed [PROD_W:0]   ph_s3 [3];
	logic signed [TERM_W-1:0] t_s4 [3];
	logic signed [DET_W-1:0]  det_s5;
	logic [ADJ_W-1:0]         adj_mag [9];

	assign elem[0] = mat.a_00;
	assign elem[1] = mat.a_01;
	assign elem[2] = mat.a_02;
	assign elem[3] = mat.a_10;
	assign elem[4] = mat.a_11;
	assign elem[5] = mat.a_12;
	assign elem[6] = mat.a_20;
	assign elem[7] = mat.a_21;
	assign elem[8] = mat.a_22;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 9; k++) begin
				p0_s1[k] <= elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]];
				p1_s1[k] <= elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
			end
			c_s1[0] <= elem[0];
			c_s1[1] <= elem[3];
			c_s1[2] <= elem[6];
		end
		if (en[1]) begin
			for (int k = 0; k < 9; k++)
				adj_s2[k] <= ADJ_W'(p0_s1[k]) - ADJ_W'(p1_s1[k]);
			c_s2 <= c_s1;
		end
		// split each first-column cofactor into an unsigned low half and a signed high half
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= c_s2[j] * $signed({1'b0, adj_s2[j][ELEM_W-1:0]});
				ph_s3[j] <= c_s2[j] * $signed(adj_s2[j][ADJ_W-1:ELEM_W]);
			end
			adj_s3 <= adj_s2;
		end
		if (en[3]) begin
			for (int j = 0; j < 3; j++)
				t_s4[j] <= (TERM_W'(ph_s3[j]) <<< ELEM_W) + TERM_W'(pl_s3[j]);
			adj_s4 <= adj_s3;
		end
		if (en[4]) begin
			det_s5 <= DET_W'(t_s4[0]) + DET_W'(t_s4[1]) + DET_W'(t_s4[2]);
			adj_s5 <= adj_s4;
		end
		if (en[5]) begin
			for (int k = 0; k < 9; k++) begin
				num_s6[k] <= NUM_W'(adj_mag[k]) << (2 * FRAC_W);
				neg_s6[k] <= adj_s5[k][ADJ_W-1] ^ det_s5[DET_W-1];
			end
			dmag_s6 <= det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
			zero_s6 <= (det_s5 == '0);
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++)
			adj_mag[k] = adj_s5[k][ADJ_W-1] ? ADJ_W'(-adj_s5[k]) : ADJ_W'(adj_s5[k]);
	end

endmodule

>>> hw/rtl/mi3_div.sv
`timescale 1ns / 1ps
module mi3_div import mi3_pkg::*; (
	input  logic                     clk,
	input  logic [DIV_ST-1:0]        en,
	input  logic [NUM_W-1:0]         num,
	input  logic [DET_W-1:0]         dmag,
	input  logic                     neg,
	input  logic                     zero,
	output logic signed [ELEM_W-1:0] res_s
);

	localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

	logic [REM_W-1:0]  r_s    [ELEM_W+1];
	logic [ELEM_W-1:0] q_s    [ELEM_W+1];
	logic [DET_W-1:0]  d_s    [ELEM_W+1];
	logic              neg_s  [ELEM_W+1];
	logic              sat_s  [ELEM_W+1];
	logic              zero_s [ELEM_W+1];

	// quotient of 2^W or more always saturates
	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s[0]    <= REM_W'(num);
			q_s[0]    <= '0;
			d_s[0]    <= dmag;
			neg_s[0]  <= neg;
			sat_s[0]  <= REM_W'(num) >= (REM_W'(dmag) << ELEM_W);
			zero_s[0] <= zero;
		end
	end

	for (genvar j = 1; j <= ELEM_W; j++) begin : g_bit
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(d_s[j-1]) << (ELEM_W - j);
		assign ge  = r_s[j-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				r_s[j]    <= ge ? r_s[j-1] - dsh : r_s[j-1];
				q_s[j]    <= q_s[j-1] | (ge ? (ELEM_W'(1) << (ELEM_W - j)) : '0);
				d_s[j]    <= d_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				sat_s[j]  <= sat_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ELEM_W+1]) begin
			if (zero_s[ELEM_W])
				res_s <= '0;
			else if (neg_s[ELEM_W]) begin
				if (sat_s[ELEM_W] || ({1'b0, q_s[ELEM_W]} > {1'b0, MIN_NEG}))
					res_s <= MIN_NEG;
				else
					res_s <= -q_s[ELEM_W];
			end else begin
				if (sat_s[ELEM_W] || q_s[ELEM_W][ELEM_W-1])
					res_s <= MAX_POS;
				else
					res_s <= q_s[ELEM_W];
			end
		end
	end

endmodule

>>> dv/matrix_inverse_3x3_tb.sv
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb;
	import mi3_pkg::*;

	localparam int ONE = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_ready;
	mat_t mat = '0;
	logic inv_valid;
	logic inv_ready = 1'b0;
	inv_t inv;

	mat_t pending_mats[$];
	inv_t inverse_queue[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	matrix_inverse_3x3 u_top (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
		.inv_valid(inv_valid), .inv_ready(inv_ready), .inv(inv)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// exact adjugate over determinant, truncated toward zero, then saturated
	function automatic inv_t invert_mat(mat_t m);
		logic signed [31:0] src[9];
		logic signed [191:0] e[9];
		logic signed [191:0] adj[9];
		logic signed [191:0] det;
		logic [191:0] amag, dmag, quo;
		logic [31:0] res[9];
		logic neg;
		inv_t r;
		src = '{m.a_00, m.a_01, m.a_02, m.a_10, m.a_11, m.a_12, m.a_20, m.a_21, m.a_22};
		for (int k = 0; k < 9; k++) e[k] = src[k];
		for (int k = 0; k < 9; k++)
			adj[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
		det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		dmag = (det < 0) ? -det : det;
		for (int k = 0; k < 9; k++) begin
			neg = (adj[k] < 0) != (det < 0);
			amag = (adj[k] < 0) ? -adj[k] : adj[k];
			quo = (amag << 32) / dmag;
			if (neg) begin
				if (quo > 192'h8000_0000) quo = 192'h8000_0000;
				quo = -quo;
			end else if (quo > 192'h7fff_ffff) begin
				quo = 192'h7fff_ffff;
			end
			res[k] = quo[31:0];
		end
		r = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8], 1'b0};
		return r;
	endfunction

	function automatic mat_t diag3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		mat_t m;
		m = '0;
		m.a_00 = x;
		m.a_11 = y;
		m.a_22 = z;
		return m;
	endfunction

	function automatic logic [31:0] small_elem();
		logic [31:0] v;
		v = {{12{1'b0}}, 4'($urandom_range(15)), 16'($urandom)};
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic mat_t rand_mat();
		mat_t m;
		int kind;
		kind = $urandom_range(99);
		for (int k = 0; k < 9; k++) begin
			if (kind < 35) m[k*32 +: 32] = $urandom;
			else if (kind < 75) m[k*32 +: 32] = small_elem();
			else begin
				case ($urandom_range(3))
					0: m[k*32 +: 32] = 32'h7fff_ffff;
					1: m[k*32 +: 32] = 32'h8000_0000;
					2: m[k*32 +: 32] = 32'($urandom_range(3)) - 1;
					default: m[k*32 +: 32] = $urandom;
				endcase
			end
		end
		// now and then copy or clear entries, which often forces a zero determinant
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(2))
				0: m.a_20 = m.a_00;
				1: m.a_00 = 0;
				default: m.a_00 = m.a_01;
			endcase
			case ($urandom_range(2))
				0: begin m.a_21 = m.a_01; m.a_22 = m.a_02; m.a_20 = m.a_00; end
				1: begin m.a_10 = 0; m.a_20 = 0; end
				default: begin m.a_10 = m.a_11; m.a_20 = m.a_21; end
			endcase
		end
		return m;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_valid <= 1'b0;
			inv_ready <= 1'b0;
		end else begin
			inv_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!mat_valid || mat_ready) begin
				if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					mat <= pending_mats.pop_front();
					mat_valid <= 1'b1;
				end else begin
					mat_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		inv_t want;
		if (arst_n) begin
			if (mat_valid && mat_ready) inverse_queue.push_back(invert_mat(mat));
			if (inv_valid && inv_ready) begin
				if (inverse_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $time, inv);
				end else begin
					want = inverse_queue.pop_front();
					for (int k = 0; k < 9; k++)
						if (inv[1 + (8-k)*32 +: 32] !== want[1 + (8-k)*32 +: 32]) begin
							errors++;
							$display("%0t: inv_%0d%0d expected %h got %h", $time, k/3, k%3,
								want[1 + (8-k)*32 +: 32], inv[1 + (8-k)*32 +: 32]);
						end
					if (inv.singular !== want.singular) begin
						errors++;
						$display("%0t: singular expected %b got %b", $time,
							want.singular, inv.singular);
					end
				end
			end
		end
	end

	initial begin
		mat_t m;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		pending_mats.push_back(diag3(ONE, ONE, ONE));
		pending_mats.push_back('0);
		pending_mats.push_back(diag3(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_mats.push_back(diag3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_mats.push_back(diag3(1, 1, 1));
		pending_mats.push_back(diag3(-1, 1, 1));
		pending_mats.push_back(diag3(2*ONE, -4*ONE, ONE/2));
		pending_mats.push_back('1);
		m = '0;
		m.a_01 = ONE; m.a_10 = ONE; m.a_22 = ONE;
		pending_mats.push_back(m);
		for (int k = 0; k < 9; k++) m[k*32 +: 32] = 32'h7fff_ffff;
		pending_mats.push_back(m);
		for (int k = 0; k < 9; k++) m[k*32 +: 32] = 32'h8000_0000;
		pending_mats.push_back(m);
		for (int k = 0; k < 9; k++) m[k*32 +: 32] = (k % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
		pending_mats.push_back(m);
		for (int k = 0; k < 9; k++) m[k*32 +: 32] = (k % 4 == 0) ? 32'h8000_0000 : 0;
		pending_mats.push_back(m);
		m = '0;
		m.a_00 = 3*ONE; m.a_01 = ONE; m.a_02 = -2*ONE;
		m.a_10 = ONE; m.a_11 = 5*ONE; m.a_12 = ONE;
		m.a_20 = -ONE; m.a_21 = 2*ONE; m.a_22 = 4*ONE + 32'h8000;
		pending_mats.push_back(m);
		for (int k = 0; k < 4; k++) pending_mats.push_back(rand_mat());
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 66) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 66) : 0;
			for (int i = 0; i < 250; i++) pending_mats.push_back(rand_mat());
			wait (pending_mats.size() == 0);
		end
		// hold until the last word is taken and every expected result is back
		wait (!mat_valid && inverse_queue.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && inverse_queue.size() == 0)
			$display("matrix_inverse_3x3: match");
		else
			$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

endmodule
